// ===== hw/rtl/bdtw_pkg.sv =====
// Shared types, constants and saturating arithmetic for the banded DTW unit.
// No dependencies.
`default_nettype none
package bdtw_pkg;
	localparam int SAMPLE_W     = 16;
	localparam int COST_W       = 48;
	localparam int RADIUS_W     = 6;
	localparam int RADIUS_RESET = 12;
	localparam int MAX_LEN_DEF  = 256;
	localparam int MAX_BAND_DEF = 32;

	typedef logic [COST_W-1:0] cost_t;
	localparam cost_t COST_INF = '1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] data;
		logic signed [SAMPLE_W-1:0] query;
		cost_t                      bound;
	} sample_t;

	// saturating add, all ones stands for infinity
	function automatic cost_t sat_add(input cost_t a, input cost_t b);
		logic [COST_W:0] s;
		begin
			s = {1'b0, a} + {1'b0, b};
			sat_add = s[COST_W] ? COST_INF : s[COST_W-1:0];
		end
	endfunction

	function automatic cost_t cost_min(input cost_t a, input cost_t b);
		cost_min = (a < b) ? a : b;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/bdtw_sample_mem.sv =====
// Sequence stores: data, query and bound tail, one write and three reads.
// Depends on bdtw_pkg.
`default_nettype none
module bdtw_sample_mem #(
	parameter int MAX_LEN = bdtw_pkg::MAX_LEN_DEF
) (
	input  wire                            clk,
	input  wire                            we,
	input  wire [$clog2(MAX_LEN)-1:0]      waddr,
	input  wire bdtw_pkg::sample_t         wdata,
	input  wire [$clog2(MAX_LEN)-1:0]      data_raddr,
	input  wire [$clog2(MAX_LEN)-1:0]      query_raddr,
	input  wire [$clog2(MAX_LEN)-1:0]      bound_raddr,
	output logic signed [bdtw_pkg::SAMPLE_W-1:0] data_rd,
	output logic signed [bdtw_pkg::SAMPLE_W-1:0] query_rd,
	output bdtw_pkg::cost_t                bound_rd
);
	logic signed [bdtw_pkg::SAMPLE_W-1:0] data_mem  [MAX_LEN];
	logic signed [bdtw_pkg::SAMPLE_W-1:0] query_mem [MAX_LEN];
	bdtw_pkg::cost_t                      bound_mem [MAX_LEN];

	always_ff @(posedge clk) begin
		if (we) begin
			data_mem[waddr]  <= wdata.data;
			query_mem[waddr] <= wdata.query;
			bound_mem[waddr] <= wdata.bound;
		end
		data_rd  <= data_mem[data_raddr];
		query_rd <= query_mem[query_raddr];
		bound_rd <= bound_mem[bound_raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bdtw_row_mem.sv =====
// Two cost rows (ping-pong banks) in one memory, one write and two reads.
// Depends on bdtw_pkg.
`default_nettype none
module bdtw_row_mem #(
	parameter int MAX_BAND = bdtw_pkg::MAX_BAND_DEF
) (
	input  wire                                  clk,
	input  wire                                  we,
	input  wire [$clog2(2*(2*MAX_BAND+1))-1:0]   waddr,
	input  wire bdtw_pkg::cost_t                 wdata,
	input  wire [$clog2(2*(2*MAX_BAND+1))-1:0]   raddr_a,
	input  wire [$clog2(2*(2*MAX_BAND+1))-1:0]   raddr_b,
	output bdtw_pkg::cost_t                      rdata_a,
	output bdtw_pkg::cost_t                      rdata_b
);
	localparam int DEPTH = 2 * (2 * MAX_BAND + 1);

	bdtw_pkg::cost_t cost_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			cost_mem[waddr] <= wdata;
		rdata_a <= cost_mem[raddr_a];
		rdata_b <= cost_mem[raddr_b];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/banded_dtw_early_abandon_unit.sv =====
// Banded DTW distance with early abandon, top level.
// Depends on bdtw_pkg, bdtw_sample_mem and bdtw_row_mem.
//
// Each accepted request stores one data sample, query sample and bound-tail
// entry. The request with tlast set (or the one filling position
// MAX_LEN-1) starts the compute phase; no request is taken until its result
// is in the output register. Compute visits rows i = 0..m-1; each row steps
// through fetching data[i] and bound[i+r+1], then one cell per cycle
// through a 3-stage read/modify/write pipe on the cost-row memory, then
// draining that pipe (row N+1 reads what row N wrote), then the abandon
// check. The band radius is clamped to MAX_BAND. The output stage holds
// one result so the next sequence can be loaded while it waits.
`default_nettype none
module banded_dtw_early_abandon_unit #(
	parameter int MAX_LEN  = bdtw_pkg::MAX_LEN_DEF,
	parameter int MAX_BAND = bdtw_pkg::MAX_BAND_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// config: band_radius
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire [bdtw_pkg::RADIUS_W-1:0] cfg_data,
	// input stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] data_sample, [31:16] query_sample, [79:32] bound_tail,
	// [127:80] abandon threshold
	input  wire [127:0] s_axis_tdata,
	input  wire         s_axis_tlast,   // last
	// result stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [47:0] distance
	output logic        m_axis_tuser    // [0] abandoned
);
	localparam int LW       = $clog2(MAX_LEN);
	localparam int RW       = $clog2(MAX_BAND + 2);
	localparam int CW       = ((LW > RW) ? LW : RW) + 2;
	localparam int ROW_LEN  = 2 * MAX_BAND + 1;
	localparam int KW       = $clog2(2 * MAX_BAND + 2);
	localparam int AW       = $clog2(2 * ROW_LEN);

	localparam logic [2:0] ST_LOAD   = 3'd0;
	localparam logic [2:0] ST_ROW_RD = 3'd1;
	localparam logic [2:0] ST_ROW_SET= 3'd2;
	localparam logic [2:0] ST_CELL   = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_CHK1   = 3'd5;
	localparam logic [2:0] ST_CHK2   = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0]                  state_q;
	logic [bdtw_pkg::RADIUS_W-1:0] radius_q;
	logic [LW-1:0]               cnt_q, i_q, m1_q, j_q, jhi_q;
	logic [RW-1:0]               r_q;
	bdtw_pkg::cost_t             bsf_q, bound_q, row_min_q, diag_q, sum_q;
	bdtw_pkg::cost_t             res_dist_q;
	logic                        res_ab_q, chk_q, bank_q, out_v_q;
	logic signed [bdtw_pkg::SAMPLE_W-1:0] data_i_q;
	logic                        out_load;

	// request decode
	bdtw_pkg::sample_t           wsample;
	logic                        in_acc, in_end;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_end        = s_axis_tlast || (cnt_q == LW'(MAX_LEN - 1));
	assign wsample.data  = s_axis_tdata[15:0];
	assign wsample.query = s_axis_tdata[31:16];
	assign wsample.bound = s_axis_tdata[79:32];

	// result moves into the output register when it is free or draining
	assign out_load      = (state_q == ST_DONE) && (!out_v_q || m_axis_tready);

	// row geometry
	logic [CW-1:0] i_x, r_x, m1_x, j_x, ipr, jlo, jhi, k_x;
	logic          chk_row;
	always_comb begin
		i_x     = CW'(i_q);
		r_x     = CW'(r_q);
		m1_x    = CW'(m1_q);
		j_x     = CW'(j_q);
		ipr     = i_x + r_x;
		jlo     = (i_x >= r_x) ? i_x - r_x : '0;
		jhi     = (ipr > m1_x) ? m1_x : ipr;
		k_x     = j_x + r_x - i_x;
		chk_row = ipr < m1_x;
	end

	// memories
	logic signed [bdtw_pkg::SAMPLE_W-1:0] data_rd, query_rd;
	bdtw_pkg::cost_t  bound_rd, diag_rd, up_rd;
	logic [LW-1:0]    bound_raddr;
	logic [AW-1:0]    raddr_a, raddr_b, waddr;
	logic [KW-1:0]    k_up;
	logic             up_ok, diag_ok;

	assign bound_raddr = chk_row ? LW'(ipr + CW'(1)) : '0;

	bdtw_sample_mem #(.MAX_LEN(MAX_LEN)) u_samples (
		.clk         (clk),
		.we          (in_acc),
		.waddr       (cnt_q),
		.wdata       (wsample),
		.data_raddr  (i_q),
		.query_raddr (j_q),
		.bound_raddr (bound_raddr),
		.data_rd     (data_rd),
		.query_rd    (query_rd),
		.bound_rd    (bound_rd)
	);

	// pipeline registers
	logic                v_s1, v_s2, v_s3;
	logic [KW-1:0]       k_s1, k_s2, k_s3;
	logic                up_ok_s1, diag_ok_s1, orig_s1, orig_s2, first_s1, first_s2;
	bdtw_pkg::cost_t     sq_s2, ud_s2, c_s3;

	always_comb begin
		up_ok   = (i_q != '0) && (k_x + CW'(1) <= (r_x << 1));
		diag_ok = (i_q != '0) && (j_q != '0);
		k_up    = up_ok ? KW'(k_x + CW'(1)) : KW'(k_x);
		raddr_a = bank_q ? AW'(KW'(k_x)) : AW'(KW'(k_x)) + AW'(ROW_LEN);
		raddr_b = bank_q ? AW'(k_up) : AW'(k_up) + AW'(ROW_LEN);
		waddr   = bank_q ? AW'(k_s3) + AW'(ROW_LEN) : AW'(k_s3);
	end

	bdtw_row_mem #(.MAX_BAND(MAX_BAND)) u_rows (
		.clk     (clk),
		.we      (v_s3),
		.waddr   (waddr),
		.wdata   (c_s3),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (diag_rd),
		.rdata_b (up_rd)
	);

	// S1: square difference, min of up and diagonal
	logic signed [bdtw_pkg::SAMPLE_W:0] diff;
	logic [bdtw_pkg::SAMPLE_W:0]        adiff;
	logic [2*bdtw_pkg::SAMPLE_W+1:0]    sq;
	bdtw_pkg::cost_t                    ud, left, c_new;
	always_comb begin
		diff  = (bdtw_pkg::SAMPLE_W+1)'(data_i_q) - (bdtw_pkg::SAMPLE_W+1)'(query_rd);
		adiff = diff[bdtw_pkg::SAMPLE_W] ? -diff : diff;
		sq    = adiff * adiff;
		ud    = bdtw_pkg::cost_min(up_ok_s1 ? up_rd : bdtw_pkg::COST_INF,
		                           diag_ok_s1 ? diag_rd : bdtw_pkg::COST_INF);
		// S2: left neighbor is the cell just finished
		left  = first_s2 ? bdtw_pkg::COST_INF : c_s3;
		c_new = orig_s2 ? sq_s2
		                : bdtw_pkg::sat_add(bdtw_pkg::cost_min(ud_s2, left), sq_s2);
	end

	always_ff @(posedge clk) begin
		k_s1       <= KW'(k_x);
		up_ok_s1   <= up_ok;
		diag_ok_s1 <= diag_ok;
		orig_s1    <= (i_q == '0) && (j_q == '0);
		first_s1   <= (j_x == jlo);
		sq_s2      <= bdtw_pkg::COST_W'(sq);
		ud_s2      <= ud;
		k_s2       <= k_s1;
		orig_s2    <= orig_s1;
		first_s2   <= first_s1;
		c_s3       <= c_new;
		k_s3       <= k_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_CELL);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			radius_q <= bdtw_pkg::RADIUS_W'(bdtw_pkg::RADIUS_RESET);
			cnt_q    <= '0;
			out_v_q  <= 1'b0;
			bank_q   <= 1'b0;
			i_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				radius_q <= cfg_data;
			if (out_load)
				out_v_q <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready)
				out_v_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (in_end) begin
							cnt_q   <= '0;
							m1_q    <= cnt_q;
							bsf_q   <= s_axis_tdata[127:80];
							i_q     <= '0;
							bank_q  <= 1'b0;
							r_q     <= (32'(radius_q) > MAX_BAND) ? RW'(MAX_BAND)
							                                      : RW'(radius_q);
							state_q <= ST_ROW_RD;
						end else begin
							cnt_q <= cnt_q + LW'(1);
						end
					end
				end
				ST_ROW_RD: state_q <= ST_ROW_SET;
				ST_ROW_SET: begin
					data_i_q  <= data_rd;
					bound_q   <= bound_rd;
					chk_q     <= chk_row;
					row_min_q <= bdtw_pkg::COST_INF;
					j_q       <= LW'(jlo);
					jhi_q     <= LW'(jhi);
					state_q   <= ST_CELL;
				end
				ST_CELL: begin
					if (j_q == jhi_q)
						state_q <= ST_DRAIN;
					else
						j_q <= j_q + LW'(1);
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3)
						state_q <= ST_CHK1;
				end
				ST_CHK1: begin
					sum_q   <= bdtw_pkg::sat_add(row_min_q, bound_q);
					state_q <= ST_CHK2;
				end
				ST_CHK2: begin
					if (chk_q && (sum_q >= bsf_q)) begin
						res_dist_q <= sum_q;
						res_ab_q   <= 1'b1;
						state_q    <= ST_DONE;
					end else if (i_q == m1_q) begin
						res_dist_q <= diag_q;
						res_ab_q   <= 1'b0;
						state_q    <= ST_DONE;
					end else begin
						i_q     <= i_q + LW'(1);
						bank_q  <= ~bank_q;
						state_q <= ST_ROW_RD;
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
			// S3 side: row minimum and the band-center cell
			if (v_s3) begin
				row_min_q <= bdtw_pkg::cost_min(row_min_q, c_s3);
				if (k_s3 == KW'(r_q))
					diag_q <= c_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= res_dist_q;
			m_axis_tuser <= res_ab_q;
		end
	end

	assign m_axis_tvalid = out_v_q;

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHK1) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("row check started with cells in flight");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q == ST_CELL))
		else $error("cell issued outside cell phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (32'(k_s3) <= 2 * 32'(r_q)))
		else $error("cost write outside band");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised without finished run");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for banded_dtw_early_abandon_unit.
// Depends on bdtw_pkg and the unit's RTL; predicts each sequence's DTW result.
`timescale 1ns / 1ps
module testbench;
	localparam int MAX_LEN  = bdtw_pkg::MAX_LEN_DEF;
	localparam int MAX_BAND = bdtw_pkg::MAX_BAND_DEF;
	localparam int ROW_LEN  = 2 * MAX_BAND + 1;
	localparam longint LIMIT = 64'd4_000_000;

	typedef struct packed {
		logic              last;
		bdtw_pkg::cost_t   bsf;
		bdtw_pkg::cost_t   bound;
		logic signed [15:0] query;
		logic signed [15:0] data;
	} dtw_req_t;

	typedef struct packed {
		logic  abandoned;
		bdtw_pkg::cost_t distance;
	} dtw_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bdtw_pkg::RADIUS_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic m_axis_tuser;

	banded_dtw_early_abandon_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// predictor state
	int unsigned radius_cfg = bdtw_pkg::RADIUS_RESET;
	int seq_len = 0;
	logic signed [15:0] data_mem [MAX_LEN];
	logic signed [15:0] query_mem [MAX_LEN];
	bdtw_pkg::cost_t bound_mem [MAX_LEN];

	dtw_req_t req_q[$];
	dtw_res_t dist_q[$];
	longint cycles = 0;
	int mismatches = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int abandons_seen = 0;
	bit sender_on = 1'b1;
	bit in_fire = 1'b0;
	int burst_left = 0;
	int stall_phase = 0;

	function automatic bdtw_pkg::cost_t sq_cost(logic signed [15:0] a,
			logic signed [15:0] b);
		logic signed [17:0] d;
		logic [16:0] u;
		begin
			d = 18'(a) - 18'(b);
			u = d[17] ? 17'(-d) : 17'(d);
			sq_cost = 48'(u) * 48'(u);
		end
	endfunction

	// banded DTW over the stored sequence, with early abandon
	function automatic dtw_res_t banded_dtw(int m, int r, bdtw_pkg::cost_t bsf);
		bdtw_pkg::cost_t now_row [ROW_LEN];
		bdtw_pkg::cost_t prev_row [ROW_LEN];
		bdtw_pkg::cost_t row_min, c, lft, up, dg, s, m3;
		dtw_res_t res;
		int jlo, jhi, k;
		begin
			for (k = 0; k < ROW_LEN; k++) begin
				now_row[k] = bdtw_pkg::COST_INF;
				prev_row[k] = bdtw_pkg::COST_INF;
			end
			res.abandoned = 1'b0;
			for (int i = 0; i < m; i++) begin
				jlo = (i - r < 0) ? 0 : i - r;
				jhi = (i + r > m - 1) ? m - 1 : i + r;
				row_min = bdtw_pkg::COST_INF;
				for (int j = jlo; j <= jhi; j++) begin
					k = j - i + r;
					if (i == 0 && j == 0) begin
						c = sq_cost(data_mem[0], query_mem[0]);
					end else begin
						lft = (j - 1 < 0 || k - 1 < 0) ? bdtw_pkg::COST_INF : now_row[k-1];
						up = (i - 1 < 0 || k + 1 > 2 * r) ? bdtw_pkg::COST_INF
							: prev_row[k+1];
						dg = (i - 1 < 0 || j - 1 < 0) ? bdtw_pkg::COST_INF : prev_row[k];
						m3 = (up < lft) ? up : lft;
						m3 = (m3 < dg) ? m3 : dg;
						s = m3 + sq_cost(data_mem[i], query_mem[j]);
						c = (s < m3) ? bdtw_pkg::COST_INF : s;
					end
					now_row[k] = c;
					if (c < row_min) row_min = c;
				end
				if (i + r < m - 1) begin
					s = row_min + bound_mem[i+r+1];
					if (s < row_min) s = bdtw_pkg::COST_INF;
					if (s >= bsf) begin
						res.abandoned = 1'b1;
						res.distance = s;
						return res;
					end
				end
				prev_row = now_row;
			end
			res.distance = prev_row[r];
			return res;
		end
	endfunction

	function automatic void predict_request(dtw_req_t q);
		int pos;
		begin
			pos = (seq_len >= MAX_LEN) ? MAX_LEN - 1 : seq_len;
			data_mem[pos] = q.data;
			query_mem[pos] = q.query;
			bound_mem[pos] = q.bound;
			if (!q.last && pos < MAX_LEN - 1) begin
				seq_len = pos + 1;
			end else begin
				dist_q.insert(dist_q.size(), banded_dtw(pos + 1,
					(radius_cfg > MAX_BAND) ? MAX_BAND : radius_cfg, q.bsf));
				seq_len = 0;
			end
		end
	endfunction

	// driver: bursts of requests separated by random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			// a held request changes only after it was accepted
			if (!s_axis_tvalid || in_fire) begin
				if (burst_left == 0) begin
					sender_on = ~sender_on;
					burst_left = sender_on ? $urandom_range(1, 40) : $urandom_range(0, 6);
				end
				if (sender_on && req_q.size() > 0) begin
					s_axis_tdata <= {req_q[0].bsf, req_q[0].bound,
						req_q[0].query, req_q[0].data};
					s_axis_tlast <= req_q[0].last;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
				if (burst_left > 0) burst_left--;
			end
			// receiver stall pattern: long ready stretches, then stutter
			stall_phase = (stall_phase + 1) % 64;
			m_axis_tready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(0, 2) != 0);
		end
	end

	// monitor: request acceptance, prediction and result checking
	always @(posedge clk) begin
		cycles <= cycles + 1;
		in_fire = arst_n && s_axis_tvalid && s_axis_tready;
		if (in_fire) begin
			predict_request(req_q[0]);
			req_q.delete(0);
			requests_sent++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (m_axis_tuser) abandons_seen++;
			if (dist_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing pending: dist=%h ab=%b",
						m_axis_tdata, m_axis_tuser);
			end else if (dist_q[0].distance !== m_axis_tdata ||
					dist_q[0].abandoned !== m_axis_tuser) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected dist=%h ab=%b, got dist=%h ab=%b",
						dist_q[0].distance, dist_q[0].abandoned,
						m_axis_tdata, m_axis_tuser);
				dist_q.delete(0);
			end else begin
				dist_q.delete(0);
			end
		end
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_sample(int spread);
		case ($urandom_range(0, 9))
			0: rand_sample = 16'sh7fff;
			1: rand_sample = 16'sh8000;
			default: rand_sample = 16'($signed($urandom_range(0, 2 * spread)) - spread);
		endcase
	endfunction

	// one sequence; bounds small enough that most runs finish, some abandon
	task automatic queue_sequence(int len, int mode);
		dtw_req_t q;
		bdtw_pkg::cost_t tail;
		begin
			tail = 48'($urandom_range(0, 4096)) * 48'(len);
			for (int n = 0; n < len; n++) begin
				q.data = (mode == 0) ? rand_sample(4096) : 16'($urandom);
				q.query = (mode == 0) ? rand_sample(4096) : 16'($urandom);
				if (mode == 2) q.bound = 48'({$urandom, $urandom});
				else if (mode == 3) q.bound = bdtw_pkg::COST_INF;
				else q.bound = tail;
				tail = (tail > 48'd4096) ? tail - 48'($urandom_range(0, 4096)) : 48'd0;
				q.last = (n == len - 1);
				case ($urandom_range(0, 3))
					0: q.bsf = bdtw_pkg::COST_INF;
					1: q.bsf = 48'({$urandom, $urandom});
					2: q.bsf = 48'($urandom) << $urandom_range(0, 16);
					default: q.bsf = 48'($urandom_range(0, 3));
				endcase
				req_q.insert(req_q.size(), q);
			end
		end
	endtask

	task automatic wait_idle();
		begin
			while (req_q.size() > 0 || dist_q.size() > 0 || s_axis_tvalid)
				@(posedge clk);
			repeat (40) @(posedge clk);
		end
	endtask

	task automatic write_radius(int unsigned r);
		begin
			@(negedge clk);
			cfg_data <= bdtw_pkg::RADIUS_W'(r);
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			radius_cfg = r;
			@(negedge clk);
			cfg_valid <= 1'b0;
		end
	endtask

	int radius_set [6] = '{0, 1, 32, 63, 5, 12};

	initial begin
		dtw_req_t q;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single items at the extremes, all-ones bounds, random bounds
		q = '{last: 1'b1, bsf: bdtw_pkg::COST_INF, bound: '0, query: 16'sh8000,
			data: 16'sh7fff};
		req_q.insert(req_q.size(), q);
		q = '{last: 1'b1, bsf: '0, bound: bdtw_pkg::COST_INF, query: 16'sh7fff,
			data: 16'sh8000};
		req_q.insert(req_q.size(), q);
		queue_sequence(3, 3);
		queue_sequence(14, 2);
		wait_idle();

		// full-length sequence: item at the top position ends it without a last bit
		write_radius(2);
		for (int n = 0; n < MAX_LEN; n++) begin
			q = '{last: 1'b0, bsf: bdtw_pkg::COST_INF, bound: '0,
				query: 16'($urandom), data: 16'($urandom)};
			req_q.insert(req_q.size(), q);
		end
		wait_idle();

		// random phases over several band settings, extremes included
		foreach (radius_set[p]) begin
			write_radius(radius_set[p]);
			for (int s = 0; s < 14; s++)
				queue_sequence(($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 10), $urandom_range(0, 3));
			wait_idle();
		end

		$display("covered %0d requests, %0d results (%0d abandoned)",
			requests_sent, results_seen, abandons_seen);
		$display("band radii 0, 1, 2, 5, 12, 32 and 63; %0d mismatches", mismatches);
		if (mismatches == 0 && dist_q.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
